@@ hw/rtl/gaussian_cubic_spline_eval_core_macros.svh @@
// Assertion macros for the cubic spline evaluator.
// Included by the top level; define ASSERT_OFF to compile the checks out.
`ifndef GAUSSIAN_CUBIC_SPLINE_EVAL_CORE_MACROS_SVH
`define GAUSSIAN_CUBIC_SPLINE_EVAL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked at every rising clock edge outside reset.
`define GCSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Condition that must never hold outside reset.
`define GCSE_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("assertion failed");
`else
`define GCSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GCSE_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ hw/rtl/gcse_pkg.sv @@
// Shared widths, codes and types of the cubic spline evaluator.
// No dependencies; used by every module of the block.
package gcse_pkg;

    localparam int XW           = 64;   // argument and coefficient width
    localparam int HW           = 32;   // half width of a split operand
    localparam int CUTW         = 62;   // cutoff register width
    localparam int VW           = 32;   // result value width
    localparam int SEGW         = 8;    // write index width
    localparam int IDX_LSB      = 54;   // lowest argument bit of the set index
    localparam int IDXW         = XW - IDX_LSB;
    localparam int SEGMENTS_DEF = 256;
    localparam int SH_TT        = 4;    // top by top shifts left
    localparam int SH_MID       = 28;   // cross terms shift right
    localparam int SH_LL        = 60;   // low by low shifts right
    localparam int OUT_LSB      = 28;   // lowest result bit of the sum

    // Item opcodes.
    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // One coefficient set.
    typedef struct packed {
        logic [XW-1:0] a;
        logic [XW-1:0] b;
        logic [XW-1:0] c;
        logic [XW-1:0] d;
    } t_coef_set;

    // Side-band flags that travel with every beat.
    typedef struct packed {
        logic eval;   // real evaluation, result comes from the sum
        logic clip;   // argument zero or above the cutoff
    } t_tag;

    // Horner working data: running value, argument, addends still to come.
    typedef struct packed {
        logic [XW-1:0] acc;
        logic [XW-1:0] x;
        logic [XW-1:0] add0;
        logic [XW-1:0] add1;
        logic [XW-1:0] add2;
    } t_hdata;

    // Four registered partial products of one split multiply.
    typedef struct packed {
        logic [XW-1:0] tt;
        logic [XW-1:0] tl;
        logic [XW-1:0] lt;
        logic [XW-1:0] ll;
    } t_prod;

endpackage

@@ hw/rtl/gcse_coef_mem.sv @@
// Coefficient set memory: one write port, one registered read port with enable.
// Depends on gcse_pkg for the coefficient set type.
module gcse_coef_mem #(
    parameter int SEGMENTS = gcse_pkg::SEGMENTS_DEF,
    parameter int AW       = $clog2(SEGMENTS)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  gcse_pkg::t_coef_set  i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output gcse_pkg::t_coef_set  o_rd_data
);

    gcse_pkg::t_coef_set r_mem [SEGMENTS];
    gcse_pkg::t_coef_set r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while the reading stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/gcse_horner_step.sv @@
// One Horner step in two stages: split multiply, then sum plus next addend.
// Depends on gcse_pkg for the beat types and shift constants.
module gcse_horner_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  gcse_pkg::t_tag    i_tag,
    input  gcse_pkg::t_hdata  i_data,
    output logic              o_rdy,
    output logic              o_vld,
    output gcse_pkg::t_tag    o_tag,
    output gcse_pkg::t_hdata  o_data,
    input  logic              i_rdy
);

    localparam int XW = gcse_pkg::XW;
    localparam int HW = gcse_pkg::HW;
    localparam int PW = 2*HW + 1;   // signed product width

    logic              r_p_vld;
    gcse_pkg::t_tag    r_p_tag;
    gcse_pkg::t_hdata  r_p_data;
    gcse_pkg::t_prod   r_p_prod;
    logic              r_a_vld;
    gcse_pkg::t_tag    r_a_tag;
    gcse_pkg::t_hdata  r_a_data;

    logic                   rdy_p;
    logic                   rdy_a;
    logic signed [HW-1:0]   v_top;
    logic signed [HW:0]     x_top;
    logic signed [HW:0]     x_low;
    logic signed [2*HW:0]   m_tt;
    logic signed [2*HW:0]   m_tl;
    logic [XW-1:0]          m_lt;
    logic [XW-1:0]          m_ll;
    gcse_pkg::t_prod        n_prod;
    logic [XW-1:0]          n_acc;
    gcse_pkg::t_hdata       n_data;

    // A stage takes a beat when it is empty or its content moves on.
    assign rdy_a = !r_a_vld || i_rdy;
    assign rdy_p = !r_p_vld || rdy_a;
    assign o_rdy = rdy_p;

    // Partial products: signed top half of the value against the unsigned
    // halves of the argument; the low half of the value is unsigned.
    always_comb begin
        v_top = $signed(i_data.acc[XW-1:HW]);
        x_top = $signed({1'b0, i_data.x[XW-1:HW]});
        x_low = $signed({1'b0, i_data.x[HW-1:0]});
        m_tt  = PW'(v_top) * PW'(x_top);
        m_tl  = PW'(v_top) * PW'(x_low);
        m_lt  = XW'(i_data.acc[HW-1:0]) * XW'(i_data.x[XW-1:HW]);
        m_ll  = XW'(i_data.acc[HW-1:0]) * XW'(i_data.x[HW-1:0]);
        n_prod.tt = m_tt[XW-1:0];
        n_prod.tl = m_tl[XW-1:0];
        n_prod.lt = m_lt;
        n_prod.ll = m_ll;
    end

    // Product stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (rdy_p) begin
            r_p_vld <= i_vld;
        end
        if (rdy_p) begin
            r_p_tag  <= i_tag;
            r_p_data <= i_data;
            r_p_prod <= n_prod;
        end
    end

    // Aligned sum of the four products and the next addend, modulo 2^64;
    // the cross term of the signed top half shifts arithmetically.
    always_comb begin
        n_acc = {r_p_prod.tt[XW-1-gcse_pkg::SH_TT:0], {gcse_pkg::SH_TT{1'b0}}}
              + {{gcse_pkg::SH_MID{r_p_prod.tl[XW-1]}}, r_p_prod.tl[XW-1:gcse_pkg::SH_MID]}
              + {{gcse_pkg::SH_MID{1'b0}}, r_p_prod.lt[XW-1:gcse_pkg::SH_MID]}
              + {{gcse_pkg::SH_LL{1'b0}}, r_p_prod.ll[XW-1:gcse_pkg::SH_LL]}
              + r_p_data.add0;
        n_data      = r_p_data;
        n_data.acc  = n_acc;
        n_data.add0 = r_p_data.add1;
        n_data.add1 = r_p_data.add2;
        n_data.add2 = '0;
    end

    // Sum stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (rdy_a) begin
            r_a_vld <= r_p_vld;
        end
        if (rdy_a) begin
            r_a_tag  <= r_p_tag;
            r_a_data <= n_data;
        end
    end

    assign o_vld  = r_a_vld;
    assign o_tag  = r_a_tag;
    assign o_data = r_a_data;

endmodule

@@ hw/rtl/gaussian_cubic_spline_eval_core.sv @@
// Piecewise cubic spline evaluator, seven-stage pipeline: table read, then
// three Horner steps of two stages each (split multiply, aligned sum).
// Throughput one beat per cycle while the output is not stalled; a result
// passes the table read register, then both registers of each step in turn.
// Synchronous active-low reset clears all valid bits and sets the cutoff to
// its maximum; coefficient tables hold garbage until written.
`include "gaussian_cubic_spline_eval_core_macros.svh"
module gaussian_cubic_spline_eval_core #(
    parameter int SEGMENTS = gcse_pkg::SEGMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [gcse_pkg::XW-1:0]     i_x,
    input  logic [gcse_pkg::SEGW-1:0]   i_segment,
    input  logic signed [gcse_pkg::XW-1:0] i_coef_a,
    input  logic signed [gcse_pkg::XW-1:0] i_coef_b,
    input  logic signed [gcse_pkg::XW-1:0] i_coef_c,
    input  logic signed [gcse_pkg::XW-1:0] i_coef_d,
    // Result output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gcse_pkg::VW-1:0]     o_value,
    output logic                        o_clipped,
    // Cutoff register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gcse_pkg::CUTW-1:0]   i_cfg_data
);

    localparam int AW   = $clog2(SEGMENTS);
    localparam int XW   = gcse_pkg::XW;
    localparam int CMPW = 12;   // wide enough for any index and SEGMENTS

    logic [gcse_pkg::CUTW-1:0] r_cutoff;
    logic                      r_s1_vld;
    gcse_pkg::t_tag            r_s1_tag;
    logic [XW-1:0]             r_s1_x;

    logic                      rdy1;
    logic                      accept;
    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    logic [gcse_pkg::IDXW-1:0] idx;
    logic                      clip;
    gcse_pkg::t_tag            n_tag;
    gcse_pkg::t_coef_set       wr_set;
    gcse_pkg::t_coef_set       rd_set;
    gcse_pkg::t_hdata          h0_data;

    logic                      h_vld  [4];
    gcse_pkg::t_tag            h_tag  [4];
    gcse_pkg::t_hdata          h_data [4];
    logic                      h_rdy  [4];

    // Cutoff register; always ready.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= '1;
        end else if (i_cfg_valid) begin
            r_cutoff <= i_cfg_data;
        end
    end

    // Input beat handshake; nothing is taken while in reset.
    assign o_in_stall = !(rdy1 && i_rst_n);
    assign accept     = i_in_valid && !o_in_stall;

    // Argument classification and table index with the top set as clamp.
    always_comb begin
        idx  = i_x[XW-1:gcse_pkg::IDX_LSB];
        clip = (i_x == '0) || (i_x > {2'b00, r_cutoff});
        if (CMPW'(idx) > CMPW'(SEGMENTS - 1)) begin
            rd_addr = AW'(SEGMENTS - 1);
        end else begin
            rd_addr = AW'(idx);
        end
        n_tag.eval = (i_opcode == gcse_pkg::OP_EVAL) && !clip;
        n_tag.clip = (i_opcode == gcse_pkg::OP_EVAL) && clip;
        wr_en = accept && (i_opcode == gcse_pkg::OP_WRITE)
                && (CMPW'(i_segment) < CMPW'(SEGMENTS));
        wr_set.a = i_coef_a;
        wr_set.b = i_coef_b;
        wr_set.c = i_coef_c;
        wr_set.d = i_coef_d;
    end

    gcse_coef_mem #(
        .SEGMENTS (SEGMENTS),
        .AW       (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_segment)),
        .i_wr_data (wr_set),
        .i_rd_en   (rdy1),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_set)
    );

    // Table read stage.
    assign rdy1 = !r_s1_vld || h_rdy[0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (rdy1) begin
            r_s1_vld <= accept;
        end
        if (rdy1) begin
            r_s1_tag <= n_tag;
            r_s1_x   <= i_x;
        end
    end

    // Horner start: cubic coefficient as running value, the rest queued.
    always_comb begin
        h0_data.acc  = rd_set.a;
        h0_data.x    = r_s1_x;
        h0_data.add0 = rd_set.b;
        h0_data.add1 = rd_set.c;
        h0_data.add2 = rd_set.d;
    end

    assign h_vld[0]  = r_s1_vld;
    assign h_tag[0]  = r_s1_tag;
    assign h_data[0] = h0_data;
    assign h_rdy[3]  = !i_out_stall;

    // Three Horner steps in a row.
    for (genvar g = 0; g < 3; g++) begin : g_step
        gcse_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (h_vld[g]),
            .i_tag   (h_tag[g]),
            .i_data  (h_data[g]),
            .o_rdy   (h_rdy[g]),
            .o_vld   (h_vld[g+1]),
            .o_tag   (h_tag[g+1]),
            .o_data  (h_data[g+1]),
            .i_rdy   (h_rdy[g+1])
        );
    end

    // Result beat straight from the last sum register.
    assign o_out_valid = h_vld[3];
    assign o_clipped   = h_tag[3].clip;
    assign o_value     = h_tag[3].eval
                         ? h_data[3].acc[gcse_pkg::OUT_LSB +: gcse_pkg::VW]
                         : '0;

    // A stall at the input out of reset means the table read stage holds a beat.
    `GCSE_ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, o_in_stall && i_rst_n, r_s1_vld)
    // A draining output frees the whole pipeline for a new beat.
    `GCSE_ASSERT_IMPLY(a_drain_ready, i_clk, i_rst_n, o_out_valid && !i_out_stall, !o_in_stall)
    // A beat is never both evaluated and clipped.
    `GCSE_ASSERT_NEVER(a_tag_excl, i_clk, i_rst_n, r_s1_vld && r_s1_tag.eval && r_s1_tag.clip)

endmodule
